// ===== sv/htach_pkg.sv =====
package htach_pkg;

    // field widths
    localparam int PP_W   = 8;
    localparam int WORD_W = 32;
    localparam int MODE_W = 2;

    // speed arithmetic: 60 s * 1000 ms * 16 for four fraction bits
    localparam int SCALE_W = 20;
    localparam logic [SCALE_W-1:0] SPEED_SCALE = SCALE_W'(960000);

    // serial divider widths
    localparam int NUM_W = WORD_W + SCALE_W;
    localparam int DEN_W = WORD_W + PP_W;
    localparam int QUO_W = WORD_W;
    localparam int REM_W = DEN_W + 1;
    localparam int CNT_W = $clog2(QUO_W + 1);

    // default depth of the averaging ring
    localparam int FILTER_TAPS_DEF = 5;

    // item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_PULSE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    // divider status toward the controller
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/htach_in_if.sv =====
interface htach_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] now_ms;

    modport source (output valid, output mode, output now_ms, input ready);
    modport sink   (input valid, input mode, input now_ms, output ready);
endinterface

// ===== sv/htach_out_if.sv =====
interface htach_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rpm_x16;
    logic [31:0] pulse_total;
    logic        too_soon;

    modport source (output valid, output rpm_x16, output pulse_total, output too_soon,
                    input ready);
    modport sink   (input valid, input rpm_x16, input pulse_total, input too_soon,
                    output ready);
endinterface

// ===== sv/htach_sdiv.sv =====
module htach_sdiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [htach_pkg::NUM_W-1:0]   num,
    input  logic [htach_pkg::DEN_W-1:0]   den,
    output logic [htach_pkg::QUO_W-1:0]   quo,
    output htach_pkg::div_stat_t          stat
);
    import htach_pkg::*;

    localparam int HI_W = NUM_W - QUO_W;

    logic [REM_W-1:0] rem_reg;
    logic [QUO_W-1:0] q_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [REM_W-1:0] trial;
    logic             fits;
    logic             sat;

    // quotient past 32 bits when the high part of the dividend reaches the divisor
    assign sat = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]} >= den;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    assign trial = {rem_reg[REM_W-2:0], q_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (sat)
                begin
                    cnt_reg  <= '0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= CNT_W'(QUO_W);
                end
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            if (sat)
            begin
                q_reg <= '1;
            end
            else
            begin
                rem_reg <= {{(REM_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]};
                q_reg   <= num[QUO_W-1:0];
            end
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            q_reg   <= {q_reg[QUO_W-2:0], fits};
        end
    end

    assign quo       = q_reg;
    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;

endmodule

// ===== sv/hall_tachometer_rpm_average.sv =====
// Hall tachometer with a moving average of the measured speed.
// in_ch takes one beat per item: mode 0 counts a sensor pulse, mode 1 reads the
// speed at time now_ms, mode 2 clears counts and ring and restarts the time base.
// Mode 3 is dropped. Only a read gives a beat on out_ch: rpm_x16, pulse_total, too_soon.
// cfg_we with cfg_wdata sets pole_pairs; a zero value is ignored. Write only when idle.
// A read whose elapsed time is at most 1 ms goes straight to the final state, and its
// result enters the output register from there. Any other read goes through a multiply
// step, a bit-serial divide for the speed (cut short when it saturates), a sum over the
// ring entries, and a second serial divide by FILTER_TAPS. The divider yields one
// quotient bit per cycle.
// in_ch is ready only while no item is in work. A finished result sits in the output
// register until taken; if out_ch stalls and the next read finishes, it waits in its
// final state, holding in_ch off, until the register frees up.
// Reset clears counts, time base, ring and index, sets pole_pairs to 1 and empties
// the output register.
module hall_tachometer_rpm_average #(
    parameter int FILTER_TAPS = htach_pkg::FILTER_TAPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    htach_in_if.sink                    in_ch,
    htach_out_if.source                 out_ch,
    input  logic                        cfg_we,
    input  logic [htach_pkg::PP_W-1:0]  cfg_wdata
);
    import htach_pkg::*;

    localparam int IDX_W = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
    localparam int SUM_W = WORD_W + $clog2(FILTER_TAPS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FILTER_TAPS - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_DIV1  = 8'b0000_0100,
        S_WAIT1 = 8'b0000_1000,
        S_SUM   = 8'b0001_0000,
        S_DIV2  = 8'b0010_0000,
        S_WAIT2 = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [PP_W-1:0]   pole_pairs_reg;
    logic [WORD_W-1:0] pulse_count_reg;
    logic [WORD_W-1:0] last_count_reg;
    logic [WORD_W-1:0] last_time_reg;
    logic [WORD_W-1:0] ring_reg [FILTER_TAPS];
    logic [IDX_W-1:0]  ring_idx_reg;
    logic [IDX_W-1:0]  walk_reg;
    logic [SUM_W-1:0]  sum_reg;

    logic [WORD_W-1:0] delta_reg;
    logic [WORD_W-1:0] elapsed_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [WORD_W-1:0] rpm_res_reg;
    logic [WORD_W-1:0] total_res_reg;
    logic              soon_res_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_rpm_reg;
    logic [WORD_W-1:0] out_total_reg;
    logic              out_soon_reg;

    logic              in_acc;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] elapsed;
    logic              too_soon;
    logic              slot_free;
    logic [NUM_W-1:0]  num_prod;
    logic [DEN_W-1:0]  den_prod;

    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [QUO_W-1:0]  div_quo;
    div_stat_t         div_st;

    // handshake
    assign in_ch.ready = state_reg == S_IDLE;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign slot_free   = !out_valid_reg || out_ch.ready;

    // deltas since the previous read
    assign delta    = pulse_count_reg - last_count_reg;
    assign elapsed  = in_ch.now_ms - last_time_reg;
    assign too_soon = elapsed <= WORD_W'(1);

    // speed numerator and denominator products
    assign num_prod = NUM_W'(delta_reg) * NUM_W'(SPEED_SCALE);
    assign den_prod = DEN_W'(pole_pairs_reg) * DEN_W'(elapsed_reg);

    // shared serial divider: speed first, then the ring mean
    assign div_start = (state_reg == S_DIV1) || (state_reg == S_DIV2);
    assign div_num   = (state_reg == S_DIV2) ? {{(NUM_W-SUM_W){1'b0}}, sum_reg} : num_reg;
    assign div_den   = (state_reg == S_DIV2) ? DEN_W'(FILTER_TAPS) : den_reg;

    htach_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .stat  (div_st)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (in_ch.mode == MODE_READ))
                begin
                    state_next = too_soon ? S_DONE : S_MUL;
                end
            end
            S_MUL:   state_next = S_DIV1;
            S_DIV1:  state_next = S_WAIT1;
            S_WAIT1:
            begin
                if (div_st.done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (walk_reg == LAST_IDX)
                begin
                    state_next = S_DIV2;
                end
            end
            S_DIV2:  state_next = S_WAIT2;
            S_WAIT2:
            begin
                if (div_st.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pole_pairs_reg  <= PP_W'(1);
            pulse_count_reg <= '0;
            last_count_reg  <= '0;
            last_time_reg   <= '0;
            ring_idx_reg    <= '0;
            walk_reg        <= '0;
            out_valid_reg   <= 1'b0;
            for (int k = 0; k < FILTER_TAPS; k++)
            begin
                ring_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we && (cfg_wdata != '0))
            begin
                pole_pairs_reg <= cfg_wdata;
            end

            // item bookkeeping
            if (in_acc)
            begin
                case (in_ch.mode)
                    MODE_PULSE:
                    begin
                        pulse_count_reg <= pulse_count_reg + 1'b1;
                    end
                    MODE_READ:
                    begin
                        last_count_reg <= pulse_count_reg;
                        last_time_reg  <= in_ch.now_ms;
                    end
                    MODE_CLEAR:
                    begin
                        pulse_count_reg <= '0;
                        last_count_reg  <= '0;
                        last_time_reg   <= in_ch.now_ms;
                        for (int k = 0; k < FILTER_TAPS; k++)
                        begin
                            ring_reg[k] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // new speed enters the ring
            if ((state_reg == S_WAIT1) && div_st.done)
            begin
                ring_reg[ring_idx_reg] <= div_quo;
                ring_idx_reg <= (ring_idx_reg == LAST_IDX) ? '0 : ring_idx_reg + 1'b1;
                walk_reg     <= '0;
            end
            else if (state_reg == S_SUM)
            begin
                walk_reg <= (walk_reg == LAST_IDX) ? '0 : walk_reg + 1'b1;
            end

            // output register
            if ((state_reg == S_DONE) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc && (in_ch.mode == MODE_READ))
        begin
            delta_reg     <= delta;
            elapsed_reg   <= elapsed;
            total_res_reg <= pulse_count_reg;
            soon_res_reg  <= too_soon;
            rpm_res_reg   <= '0;
        end

        if (state_reg == S_MUL)
        begin
            num_reg <= num_prod;
            den_reg <= den_prod;
        end

        // ring sum, one entry per cycle
        if ((state_reg == S_WAIT1) && div_st.done)
        begin
            sum_reg <= '0;
        end
        else if (state_reg == S_SUM)
        begin
            sum_reg <= sum_reg + SUM_W'(ring_reg[walk_reg]);
        end

        if ((state_reg == S_WAIT2) && div_st.done)
        begin
            rpm_res_reg <= div_quo;
        end

        if ((state_reg == S_DONE) && slot_free)
        begin
            out_rpm_reg   <= rpm_res_reg;
            out_total_reg <= total_res_reg;
            out_soon_reg  <= soon_res_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.rpm_x16     = out_rpm_reg;
    assign out_ch.pulse_total = out_total_reg;
    assign out_ch.too_soon    = out_soon_reg;

    // ring index never leaves the ring
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_idx_reg <= LAST_IDX)
        else $error("ring index out of range");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> ((state_reg == S_WAIT1) || (state_reg == S_WAIT2)))
        else $error("divider done outside a wait state");

    // a too-soon result reports zero speed
    a_soon_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.too_soon) |-> (out_ch.rpm_x16 == '0))
        else $error("too-soon result with nonzero speed");

    // a pulse beat bumps the count by one
    a_pulse_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_ch.mode == MODE_PULSE))
        |=> (pulse_count_reg == $past(pulse_count_reg) + 1'b1))
        else $error("pulse count did not advance");

endmodule

// ===== tb/htach_checker.sv =====
`timescale 1ns / 100ps

module htach_checker
    import htach_pkg::*;
#(
    parameter int TAPS = FILTER_TAPS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    htach_in_if             in_ch,
    htach_out_if            out_ch,
    input  logic            cfg_we,
    input  logic [PP_W-1:0] cfg_wdata,
    output int              fails,
    output int              pending
);

    // one speed reading as it leaves the block
    typedef struct packed {
        logic [WORD_W-1:0] rpm_x16;
        logic [WORD_W-1:0] pulse_total;
        logic              too_soon;
    } reading_t;

    // shadow of the tachometer state
    logic [PP_W-1:0]   pole_q;
    logic [WORD_W-1:0] pulse_cnt;
    logic [WORD_W-1:0] last_cnt;
    logic [WORD_W-1:0] last_time;
    logic [WORD_W-1:0] speed_ring [TAPS];
    int unsigned       ring_pos;
    int unsigned       err_total;

    // readings predicted but not yet seen on out_ch
    reading_t readings_q [$];

    // one ring entry: delta * 960000 / (pole pairs * elapsed), saturated
    function automatic logic [WORD_W-1:0] speed_x16(input logic [WORD_W-1:0] delta,
                                                    input logic [WORD_W-1:0] elapsed,
                                                    input logic [PP_W-1:0]   pp);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        num = 64'(delta) * 64'(SPEED_SCALE);
        den = 64'(pp) * 64'(elapsed);
        quo = num / den;
        return (quo > 64'hFFFF_FFFF) ? '1 : quo[WORD_W-1:0];
    endfunction

    // floor of the ring mean
    function automatic logic [WORD_W-1:0] ring_average();
        logic [63:0] sum;
        sum = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            sum += 64'(speed_ring[k]);
        end
        return WORD_W'(sum / 64'(TAPS));
    endfunction

    // advance the shadow state by one accepted item
    function automatic void track_item(input logic [MODE_W-1:0] m,
                                       input logic [WORD_W-1:0] t);
        logic [WORD_W-1:0] delta;
        logic [WORD_W-1:0] elapsed;
        reading_t          r;
        case (m)
            MODE_PULSE:
            begin
                pulse_cnt = pulse_cnt + 1'b1;
            end
            MODE_READ:
            begin
                delta         = pulse_cnt - last_cnt;
                elapsed       = t - last_time;
                last_cnt      = pulse_cnt;
                last_time     = t;
                r.pulse_total = pulse_cnt;
                if (elapsed <= 1)
                begin
                    // read too soon: ring untouched
                    r.rpm_x16  = '0;
                    r.too_soon = 1'b1;
                end
                else
                begin
                    speed_ring[ring_pos] = speed_x16(delta, elapsed, pole_q);
                    ring_pos   = (ring_pos + 1) % TAPS;
                    r.rpm_x16  = ring_average();
                    r.too_soon = 1'b0;
                end
                readings_q.push_back(r);
            end
            MODE_CLEAR:
            begin
                // index is kept
                pulse_cnt = '0;
                last_cnt  = '0;
                last_time = t;
                for (int k = 0; k < TAPS; k++)
                begin
                    speed_ring[k] = '0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void compare_field(input string fname, input logic [WORD_W-1:0] want,
                                          input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            err_total++;
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, fname, want, got);
        end
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_q    = 8'd1;
            pulse_cnt = '0;
            last_cnt  = '0;
            last_time = '0;
            ring_pos  = 0;
            err_total = 0;
            for (int k = 0; k < TAPS; k++)
            begin
                speed_ring[k] = '0;
            end
            readings_q.delete();
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                if (readings_q.size() == 0)
                begin
                    err_total++;
                    $display("%0t ns: unexpected result beat, expected none actual %h %h %b",
                             $time, out_ch.rpm_x16, out_ch.pulse_total, out_ch.too_soon);
                end
                else
                begin
                    compare_field("rpm_x16", readings_q[0].rpm_x16, out_ch.rpm_x16);
                    compare_field("pulse_total", readings_q[0].pulse_total,
                                  out_ch.pulse_total);
                    compare_field("too_soon", WORD_W'(readings_q[0].too_soon),
                                  WORD_W'(out_ch.too_soon));
                    void'(readings_q.pop_front());
                end
            end

            // input beat
            if (in_ch.valid && in_ch.ready)
            begin
                track_item(in_ch.mode, in_ch.now_ms);
            end

            // register write, zero is dropped
            if (cfg_we && cfg_wdata != '0)
            begin
                pole_q = cfg_wdata;
            end

            fails   <= err_total;
            pending <= readings_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import htach_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 225;
    localparam int HOLD_CYCLES = 700;
    localparam int DRAIN_WAIT  = 100;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [PP_W-1:0] cfg_wdata;
    int              fail_count;
    int              open_reads;

    // stimulus controls
    bit                sender_idle_en;
    bit                sink_idle_en;
    bit                hold_req;
    logic [WORD_W-1:0] clock_ms;
    int                items_sent;
    logic [PP_W-1:0]   pole_plan [5];

    htach_in_if  in_ch ();
    htach_out_if out_ch ();

    hall_tachometer_rpm_average u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    htach_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fails     (fail_count),
        .pending   (open_reads)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // offer one beat, with an optional idle burst first
    task automatic offer_item(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] t);
        int gap;
        gap = 0;
        if (sender_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.mode   <= m;
        in_ch.now_ms <= t;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (m != MODE_UNUSED)
            items_sent++;
    endtask

    // wait for every reading to come out and the block to go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (open_reads != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_pole(input logic [PP_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // up to 200 pulses then a read at a chosen elapsed time
    task automatic measure();
        int                n;
        logic [WORD_W-1:0] el;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 8);
        repeat (n) offer_item(MODE_PULSE, $urandom());
        case ($urandom_range(0, 9))
            0:       el = $urandom_range(0, 1);
            1, 2, 3: el = $urandom_range(2, 40);
            4, 5:    el = $urandom_range(41, 100000);
            6:       el = $urandom();
            default: el = $urandom_range(2, 5);
        endcase
        clock_ms = clock_ms + el;
        offer_item(MODE_READ, clock_ms);
    endtask

    // stray items: clears, unused mode, reads at any time and pulses
    task automatic noise_item();
        logic [WORD_W-1:0] t;
        t = $urandom();
        case ($urandom_range(0, 3))
            0:
            begin
                clock_ms = t;
                offer_item(MODE_CLEAR, t);
            end
            1: offer_item(MODE_UNUSED, t);
            2:
            begin
                clock_ms = t;
                offer_item(MODE_READ, t);
            end
            default: offer_item(MODE_PULSE, t);
        endcase
    endtask

    // receiver: ready bursts, idle bursts and one long hold-off
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        in_ch.valid    <= 1'b0;
        in_ch.mode     <= MODE_PULSE;
        in_ch.now_ms   <= '0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        rst_n          <= 1'b0;
        sender_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
        hold_req       = 1'b0;
        items_sent     = 0;
        clock_ms       = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: too soon at zero and one ms, wrap of time, clear, unused mode
        offer_item(MODE_READ, 32'd0);
        repeat (2) offer_item(MODE_PULSE, 32'hFFFF_FFFF);
        offer_item(MODE_READ, 32'd1);
        repeat (3) offer_item(MODE_PULSE, 32'd0);
        offer_item(MODE_READ, 32'd3);
        offer_item(MODE_READ, 32'd2);
        offer_item(MODE_READ, 32'hFFFF_FFFF);
        offer_item(MODE_PULSE, 32'd0);
        offer_item(MODE_READ, 32'd4);
        offer_item(MODE_UNUSED, 32'hFFFF_FFFF);
        offer_item(MODE_CLEAR, 32'hFFFF_FFFE);
        offer_item(MODE_PULSE, 32'd0);
        offer_item(MODE_READ, 32'd3);
        offer_item(MODE_READ, 32'd3);
        offer_item(MODE_CLEAR, 32'd0);
        offer_item(MODE_READ, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FFFF;

        // random phases, each after a pole pair write; the zero write of phase 1 is dropped
        pole_plan[0] = 8'd255;
        pole_plan[1] = 8'd0;
        pole_plan[2] = 8'($urandom_range(2, 254));
        pole_plan[3] = 8'd1;
        pole_plan[4] = 8'($urandom_range(2, 16));
        for (int ph = 0; ph < 5; ph++)
        begin
            int goal;
            write_pole(pole_plan[ph]);
            if (ph == 1)
                hold_req = 1'b1;
            if (ph == 4)
            begin
                sender_idle_en = 1'b0;
                sink_idle_en   = 1'b0;
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                if ($urandom_range(0, 4) == 0)
                    noise_item();
                else
                    measure();
            end
        end

        settle();
        if (fail_count == 0)
            $display("hall_tachometer_rpm_average test passed");
        else
            $display("hall_tachometer_rpm_average test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #15_000_000;
        $display("hall_tachometer_rpm_average test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/htach_pkg.sv
sv/htach_in_if.sv
sv/htach_out_if.sv
sv/htach_sdiv.sv
sv/hall_tachometer_rpm_average.sv
tb/htach_checker.sv
tb/tb.sv
